/* rtl/amwv_pkg.sv */
// ----------------------------------------------------------------------------
// amwv_pkg: shared types and constants
// Widths, window length and the front-to-back queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none
package amwv_pkg;
  localparam int WindowLen = 200;
  localparam int SlotW     = $clog2(WindowLen);
  localparam int CountW    = $clog2(WindowLen + 1);
  localparam int MagW      = 16;
  localparam int SqW       = 32;
  localparam int SumW      = 24;
  localparam int SqSumW    = 40;
  localparam int NumW      = 64;
  localparam int DenW      = 16;
  localparam int VarW      = 30;
  localparam logic [VarW-1:0] VarMax = {VarW{1'b1}};

  typedef struct packed {
    logic [SqW-1:0] sq;
  } amwv_job_t;
endpackage
`default_nettype wire

/* rtl/amwv_in_if.sv */
// ----------------------------------------------------------------------------
// amwv_in_if: sample channel
// Valid/ready channel carrying one three-axis sample.
// ----------------------------------------------------------------------------
`default_nettype none
interface amwv_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface
`default_nettype wire

/* rtl/amwv_out_if.sv */
// ----------------------------------------------------------------------------
// amwv_out_if: result channel
// Valid/ready channel carrying one magnitude and window statistics.
// ----------------------------------------------------------------------------
`default_nettype none
interface amwv_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] magnitude;
  logic [7:0]  fill_count;
  logic [29:0] window_variance;
  logic        variance_valid;
  modport source (output valid, magnitude, fill_count, window_variance,
                  variance_valid, input ready);
  modport sink (input valid, magnitude, fill_count, window_variance,
                variance_valid, output ready);
endinterface
`default_nettype wire

/* rtl/amwv_ram.sv */
// ----------------------------------------------------------------------------
// amwv_ram: generic single-port RAM
// One access per cycle: optional write plus a read of the old entry, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module amwv_ram #(
  parameter int Width = 16,
  parameter int Depth = 200
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  // optionally write one entry; always read it
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* rtl/amwv_front.sv */
// ----------------------------------------------------------------------------
// amwv_front: sample intake
// Accepts a sample, squares the axes one at a time, queues the sum.
// ----------------------------------------------------------------------------
`default_nettype none
module amwv_front import amwv_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  amwv_in_if.sink    in_ch,
  output logic       q_valid,
  output amwv_job_t  q_job,
  input  wire logic  q_ready
);
  logic [15:0] ax_r, ay_r, az_r;
  logic [1:0]  step_r;
  logic        busy_r;
  logic [SqW-1:0] acc_r;
  logic        full_r;
  logic [15:0] cur;

  assign in_ch.ready = !busy_r;
  assign q_valid = full_r;

  always_comb begin
    unique case (step_r)
      2'd0:    cur = ax_r;
      2'd1:    cur = ay_r;
      default: cur = az_r;
    endcase
  end

  // take |x|,|y|,|z| then accumulate one square per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      full_r <= 1'b0;
      step_r <= '0;
    end else begin
      if (busy_r && step_r == 2'd3 && (!full_r || q_ready)) full_r <= 1'b1;
      else if (full_r && q_ready) full_r <= 1'b0;
      if (in_ch.valid && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= '0;
        acc_r  <= '0;
        ax_r   <= in_ch.accel_x[15] ? 16'(-in_ch.accel_x) : in_ch.accel_x;
        ay_r   <= in_ch.accel_y[15] ? 16'(-in_ch.accel_y) : in_ch.accel_y;
        az_r   <= in_ch.accel_z[15] ? 16'(-in_ch.accel_z) : in_ch.accel_z;
      end else if (busy_r && step_r != 2'd3) begin
        acc_r  <= acc_r + SqW'(cur * cur);
        step_r <= step_r + 2'd1;
      end else if (busy_r && (!full_r || q_ready)) begin
        q_job.sq <= acc_r;
        busy_r   <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/amwv_back.sv */
// ----------------------------------------------------------------------------
// amwv_back: window statistics engine
// Square root, ring update, running sums and iterative variance divide.
// ----------------------------------------------------------------------------
`default_nettype none
module amwv_back import amwv_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  amwv_job_t  q_job,
  output logic       q_ready,
  amwv_out_if.source out_ch
);
  typedef enum logic [3:0] {
    S_IDLE, S_SQRT, S_RDOLD, S_WAIT, S_SUB, S_SQ, S_ADD, S_NUM1, S_NUM2,
    S_NUM3, S_DIV, S_OUT
  } state_t;

  state_t state_r;
  logic [SqW-1:0]    v_r, root_r, bit_r;
  logic [SlotW-1:0]  slot_r;
  logic [CountW-1:0] cnt_r;
  logic [SumW-1:0]   sum_r;
  logic [SqSumW-1:0] sqsum_r;
  logic [MagW-1:0]   mag_r, old_r;
  logic [31:0]       prod_r;
  logic [NumW-1:0]   num_r, rem_r, t1_r;
  logic [DenW-1:0]   den_r;
  logic [6:0]        it_r;
  logic              ram_we;
  logic [MagW-1:0]   ram_q;
  logic [NumW:0]     trial;
  logic [SqW-1:0]    rb;

  assign q_ready = (state_r == S_IDLE);
  assign ram_we  = (state_r == S_ADD);
  assign rb      = root_r + bit_r;
  assign trial   = {rem_r[NumW-1:0], num_r[NumW-1]} - (NumW+1)'(den_r);

  amwv_ram #(.Width(MagW), .Depth(WindowLen)) u_ring (
    .clk(clk), .we(ram_we), .addr(slot_r), .wdata(mag_r), .rdata(ram_q));

  // sequence one item through root, window update and division
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_ch.valid <= 1'b0;
      slot_r <= '0;
      cnt_r <= '0;
      sum_r <= '0;
      sqsum_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (q_valid) begin
          v_r <= q_job.sq;
          root_r <= '0;
          bit_r <= 32'h4000_0000;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (bit_r == '0) begin
            mag_r <= MagW'(root_r);
            state_r <= S_RDOLD;
          end else begin
            if (v_r >= rb) begin
              v_r <= v_r - rb;
              root_r <= (root_r >> 1) + bit_r;
            end else root_r <= root_r >> 1;
            bit_r <= bit_r >> 2;
          end
        end
        S_RDOLD: state_r <= S_WAIT;
        S_WAIT: begin
          old_r <= ram_q;
          prod_r <= ram_q * ram_q;
          state_r <= S_SUB;
        end
        S_SUB: begin
          // drop the oldest once full
          if (cnt_r == CountW'(WindowLen)) begin
            sum_r <= sum_r - SumW'(old_r);
            sqsum_r <= sqsum_r - SqSumW'(prod_r);
          end else cnt_r <= cnt_r + 1'b1;
          prod_r <= mag_r * mag_r;
          state_r <= S_SQ;
        end
        S_SQ: begin
          sum_r <= sum_r + SumW'(mag_r);
          sqsum_r <= sqsum_r + SqSumW'(prod_r);
          state_r <= S_ADD;
        end
        S_ADD: begin
          slot_r <= (slot_r == SlotW'(WindowLen-1)) ? '0 : slot_r + 1'b1;
          den_r <= DenW'(cnt_r) * DenW'(cnt_r - 1'b1);
          state_r <= S_NUM1;
        end
        S_NUM1: begin
          t1_r <= NumW'(sqsum_r) * NumW'(cnt_r);
          state_r <= S_NUM2;
        end
        S_NUM2: begin
          num_r <= NumW'(sum_r) * NumW'(sum_r);
          state_r <= S_NUM3;
        end
        S_NUM3: begin
          num_r <= t1_r - num_r;
          rem_r <= '0;
          it_r <= '0;
          state_r <= (cnt_r < CountW'(2)) ? S_OUT : S_DIV;
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (!trial[NumW]) rem_r <= trial[NumW-1:0];
          else rem_r <= {rem_r[NumW-2:0], num_r[NumW-1]};
          num_r <= {num_r[NumW-2:0], ~trial[NumW]};
          it_r <= it_r + 1'b1;
          if (it_r == 7'd63) state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            out_ch.magnitude <= mag_r;
            out_ch.fill_count <= 8'(cnt_r);
            out_ch.variance_valid <= (cnt_r >= CountW'(2));
            out_ch.window_variance <= (cnt_r < CountW'(2)) ? '0 :
              (num_r > NumW'(VarMax)) ? VarMax : VarW'(num_r);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (out_ch.valid && out_ch.ready && state_r != S_OUT)
        out_ch.valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* rtl/accel_magnitude_window_variance.sv */
// ----------------------------------------------------------------------------
// accel_magnitude_window_variance: top level
// Accelerometer magnitude with sliding 200-sample variance.
// ----------------------------------------------------------------------------
// Each sample yields one result: floor magnitude, window fill count and floor
// sample variance of the last 200 magnitudes. The back end takes one item at a
// time, through the square root and the 64-step restoring divider, and waits in
// its output state while the result is not taken; the front end squares the next
// sample meanwhile.
`default_nettype none
module accel_magnitude_window_variance import amwv_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  amwv_in_if.sink  in_ch,
  amwv_out_if.source out_ch
);
  logic      q_valid, q_ready;
  amwv_job_t q_job;

  amwv_front u_front (.clk, .rst_n, .in_ch, .q_valid, .q_job, .q_ready);
  amwv_back  u_back  (.clk, .rst_n, .q_valid, .q_job, .q_ready, .out_ch);

  // checks
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.fill_count != 8'd0) else $error("fill zero");
  a_vv: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.variance_valid |-> out_ch.window_variance == '0)
    else $error("variance without valid");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && !q_ready |=> q_valid && $stable(q_job)) else $error("queue drop");
endmodule
`default_nettype wire
